// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check prop at every rising clock edge, reset included.
`define ASSERT_CLK_NR(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/cfr_pkg.sv =====
`timescale 1ns / 1ps

package cfr_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int OUT_W     = 20;
    localparam int PROD_W    = 32;
    localparam int FRAC_BITS = 15;
    localparam int NUM_COEF  = 7;
    localparam int CFG_IDX_W = 3;

    // Register map: coefficient i sits at index CFG_COEF_0 + i.
    localparam int CFG_COEF_0 = 0;

    typedef logic [SAMPLE_W-1:0]        t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [OUT_W-1:0]    t_filt;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;

    localparam t_coef COEF_RESET [NUM_COEF] = '{
        16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0
    };

    // Flow control of the window stage into the multiply stage.
    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

endpackage

// ===== hw/rtl/cfr_in_if.sv =====
`timescale 1ns / 1ps

interface cfr_in_if;
    import cfr_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;
    logic    last_in_row;

    modport source (output valid, output sample, output last_in_row, input ready);
    modport sink   (input valid, input sample, input last_in_row, output ready);
endinterface

// ===== hw/rtl/cfr_out_if.sv =====
`timescale 1ns / 1ps

interface cfr_out_if;
    import cfr_pkg::*;

    logic  valid;
    logic  ready;
    t_filt filtered;
    logic  last_out;

    modport source (output valid, output filtered, output last_out, input ready);
    modport sink   (input valid, input filtered, input last_out, output ready);
endinterface

// ===== hw/rtl/cfr_mac.sv =====
`timescale 1ns / 1ps

module cfr_mac #(
    parameter int TAPS = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cfr_pkg::t_stage_ctl   i_s1,
    input  cfr_pkg::t_sample      i_win  [TAPS],
    input  cfr_pkg::t_coef        i_coef [TAPS],
    output logic                  o_take,
    cfr_out_if.source             o_filt
);
    import cfr_pkg::*;

    localparam int SUM_W = PROD_W + $clog2(TAPS + 1);

    logic                    r_v2;
    logic                    r_last2;
    t_prod                   r_prod [TAPS];
    logic                    r_v3;
    logic                    r_last3;
    t_filt                   r_filt;
    logic                    en2;
    logic                    en3;
    logic signed [SUM_W-1:0] n_sum;

    assign en3    = !r_v3 || o_filt.ready;
    assign en2    = !r_v2 || en3;
    assign o_take = en2;

    always_comb begin
        n_sum = '0;
        for (int t = 0; t < TAPS; t++) begin
            n_sum = n_sum + SUM_W'(r_prod[t]);
        end
    end

    // Multiply stage: unsigned sample times signed coefficient fits 32 bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= i_s1.valid;
        end
        if (en2) begin
            r_last2 <= i_s1.last;
            for (int t = 0; t < TAPS; t++) begin
                r_prod[t] <= PROD_W'($signed({1'b0, i_win[t]}) * i_coef[t]);
            end
        end
    end

    // Sum and floor-shift into the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
        if (en3) begin
            r_last3 <= r_last2;
            r_filt  <= n_sum[FRAC_BITS + OUT_W - 1:FRAC_BITS];
        end
    end

    assign o_filt.valid    = r_v3;
    assign o_filt.filtered = r_filt;
    assign o_filt.last_out = r_last3;

endmodule

// ===== hw/rtl/centered_zero_padded_fir_row_top.sv =====
`timescale 1ns / 1ps
// Centered zero-padded FIR over one image row ("same" convolution).
// i_row (valid/ready) carries unsigned 16-bit samples; last_in_row marks the
// end of a row. o_filt (valid/ready) carries one 20-bit signed result per
// sample, floor(sum(sample * coef) / 2^15), with last_out on the row's final
// result. Samples outside the row count as zero.
// Coefficients are written through i_cfg_we / i_cfg_idx / i_cfg_data while
// idle; index i writes tap i, indexes at or above TAPS are ignored.
// Throughput: one request per cycle inside a row while the receiver does not
// stall. After the request that carries last_in_row, i_row.ready stays low
// while the flush counter shifts TAPS/2 zeros into the window.
// A result passes the window, multiply and sum stages; the sum stage is the
// output register.
// Reset (synchronous, active low) clears the sample history, the row
// position, all pipeline valids, and loads coef 3 = 32767, others 0.
// When the receiver stalls, each stage holds once the stage after it is
// full; bubbles still fill, and i_row.ready drops when the window stage
// cannot advance or while a row is flushed.
module centered_zero_padded_fir_row_top #(
    parameter int TAPS = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  cfr_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [15:0]           i_cfg_data,
    cfr_in_if.sink                i_row,
    cfr_out_if.source             o_filt
);
    import cfr_pkg::*;

    localparam int HALF_TAPS = TAPS / 2;
    localparam int HD        = (TAPS > 1) ? TAPS - 1 : 1;
    localparam int FW        = (HALF_TAPS > 0) ? $clog2(HALF_TAPS + 1) : 1;
    localparam logic [FW-1:0] HALF_W = FW'(HALF_TAPS);
    localparam logic [FW-1:0] ONE_W  = FW'(1);

    t_coef          r_coef [TAPS];
    t_sample        r_hist [HD];
    logic [FW-1:0]  r_pos;
    logic [FW-1:0]  r_flush_left;
    logic           r_s1_valid;
    logic           r_s1_last;
    t_sample        r_s1_win [TAPS];

    t_sample        n_win [TAPS];
    t_sample        new_sample;
    t_stage_ctl     s1_ctl;
    logic           flushing;
    logic           accept;
    logic           step;
    logic           emit;
    logic           emit_last;
    logic           end_row;
    logic           en1;
    logic           mac_take;

    // Tap registers; only the first TAPS are kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_coef[i] <= COEF_RESET[i];
            end
        end else if (i_cfg_we) begin
            for (int i = 0; i < TAPS; i++) begin
                if (i_cfg_idx == t_cfg_idx'(CFG_COEF_0 + i)) begin
                    r_coef[i] <= $signed(i_cfg_data);
                end
            end
        end
    end

    assign flushing    = (r_flush_left != '0);
    assign en1         = !r_s1_valid || mac_take;
    assign i_row.ready = !flushing && en1;
    assign accept      = i_row.valid && i_row.ready;
    // A flush step shifts a zero in as if the row went on.
    assign step        = accept || (flushing && en1);
    assign new_sample  = flushing ? '0 : i_row.sample;
    // Position saturates at TAPS/2: a window is due once the center is filled.
    assign emit        = step && (r_pos == HALF_W);
    assign end_row     = flushing ? (r_flush_left == ONE_W)
                                  : (i_row.last_in_row && (HALF_TAPS == 0));
    assign emit_last   = end_row;

    always_comb begin
        n_win[0] = new_sample;
        for (int t = 1; t < TAPS; t++) begin
            n_win[t] = r_hist[t-1];
        end
    end

    // History, row position and flush count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < HD; t++) begin
                r_hist[t] <= '0;
            end
            r_pos        <= '0;
            r_flush_left <= '0;
        end else if (step) begin
            if (end_row) begin
                // Drop the row: clear the delay line for the next one.
                for (int t = 0; t < HD; t++) begin
                    r_hist[t] <= '0;
                end
                r_pos        <= '0;
                r_flush_left <= '0;
            end else begin
                r_hist[0] <= new_sample;
                for (int t = 1; t < HD; t++) begin
                    r_hist[t] <= r_hist[t-1];
                end
                if (r_pos != HALF_W) begin
                    r_pos <= r_pos + ONE_W;
                end
                if (flushing) begin
                    r_flush_left <= r_flush_left - ONE_W;
                end else if (i_row.last_in_row) begin
                    r_flush_left <= HALF_W;
                end
            end
        end
    end

    // Window stage: advance when the multiply stage can take it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= emit;
        end
        if (en1 && emit) begin
            r_s1_last <= emit_last;
            for (int t = 0; t < TAPS; t++) begin
                r_s1_win[t] <= n_win[t];
            end
        end
    end

    assign s1_ctl.valid = r_s1_valid;
    assign s1_ctl.last  = r_s1_last;

    cfr_mac #(
        .TAPS (TAPS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1_ctl),
        .i_win   (r_s1_win),
        .i_coef  (r_coef),
        .o_take  (mac_take),
        .o_filt  (o_filt)
    );

endmodule

// ===== hw/rtl/cfr_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfr_checker #(
    parameter int TAPS = 7
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_in_last,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input cfr_pkg::t_filt     i_out_filtered,
    input logic               i_out_last
);
    import cfr_pkg::*;

    localparam int HALF_TAPS = TAPS / 2;

    // Hold a stalled result unchanged.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_filtered) && $stable(i_out_last)))
    // No result right after reset.
    `ASSERT_CLK_NR(a_reset_empty, i_clk, (!i_rst_n) |=> !i_out_valid)
    // Results stay within the reachable range.
    `ASSERT_CLK(a_out_range, i_clk, i_rst_n, i_out_valid |-> ((i_out_filtered >= -20'sd458745) && (i_out_filtered <= 20'sd458745)))
    // The end of a row blocks new requests during the flush.
    `ASSERT_CLK(a_flush_block, i_clk, i_rst_n, (i_in_valid && i_in_ready && i_in_last && (HALF_TAPS > 0)) |=> !i_in_ready)

endmodule

bind centered_zero_padded_fir_row_top cfr_checker #(
    .TAPS (TAPS)
) u_cfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_row.valid),
    .i_in_ready     (i_row.ready),
    .i_in_last      (i_row.last_in_row),
    .i_out_valid    (o_filt.valid),
    .i_out_ready    (o_filt.ready),
    .i_out_filtered (o_filt.filtered),
    .i_out_last     (o_filt.last_out)
);
